FILE: rtl/lreg_pkg.sv
// Shared types, constants and helper functions of the LED ring effect generator.
package lreg_pkg;

    localparam int PIXEL_COUNT = 12;
    localparam int PIX_W       = $clog2(PIXEL_COUNT);
    localparam int SCAN_MOD    = 2 * PIXEL_COUNT - 2;
    localparam int SCAN_W      = $clog2(SCAN_MOD);
    localparam int WIPE_MOD    = PIXEL_COUNT + 4;
    localparam int WIPE_W      = $clog2(WIPE_MOD);

    // rainbow hue arithmetic, all scaled by PIXEL_COUNT
    localparam int HUE_W     = 13;
    localparam int HUE_D     = 60 * PIXEL_COUNT;
    localparam int HUE_RSTEP = 360 % HUE_D;
    localparam int HUE_QSTEP = 360 / HUE_D;
    localparam int UP_A      = (255 * HUE_RSTEP) / HUE_D;
    localparam int UP_B      = (255 * HUE_RSTEP) % HUE_D;

    localparam logic [31:0] LFSR_SEED = 32'h1D872B41;
    localparam logic [31:0] LFSR_MASK = 32'h80200003;

    localparam logic [15:0] K_BREATH = 16'd522;
    localparam logic [15:0] K_PULSE  = 16'd4915;
    localparam logic [15:0] K_LISTEN = 16'd834;
    localparam logic [15:0] K_TALK   = 16'd2608;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_RED   = 3'd1;
    localparam logic [2:0] CFG_GREEN = 3'd2;
    localparam logic [2:0] CFG_BLUE  = 3'd3;

    typedef enum logic [3:0] {
        MODE_OFF       = 4'd0,
        MODE_SOLID     = 4'd1,
        MODE_RAINBOW   = 4'd2,
        MODE_BREATHING = 4'd3,
        MODE_PULSE     = 4'd4,
        MODE_SCANNER   = 4'd5,
        MODE_WIPE      = 4'd6,
        MODE_SPARKLE   = 4'd7,
        MODE_POLICE    = 4'd8,
        MODE_FIRE      = 4'd9,
        MODE_CHASE     = 4'd10,
        MODE_THEATER   = 4'd11,
        MODE_LISTENING = 4'd12,
        MODE_THINKING  = 4'd13,
        MODE_TALKING   = 4'd14,
        MODE_RECORDING = 4'd15
    } t_mode;

    // per-frame snapshot handed from front to back
    typedef struct packed {
        t_mode              mode;
        logic               blink;
        logic [7:0]         amp;
        logic [2:0]         hue_tens;
        logic [3:0]         hue_ones;
        logic [PIX_W-1:0]   scan_idx;
        logic [WIPE_W-1:0]  wipe_pos;
        logic [PIX_W-1:0]   mod_n;
        logic [1:0]         mod3;
        logic               police_red;
    } t_frame_desc;

    function automatic logic [7:0] sine_quarter(input logic [6:0] k);
        logic [7:0] v;
        case (k)
            7'd0: v = 8'd0;     7'd1: v = 8'd6;     7'd2: v = 8'd13;    7'd3: v = 8'd19;
            7'd4: v = 8'd25;    7'd5: v = 8'd31;    7'd6: v = 8'd37;    7'd7: v = 8'd44;
            7'd8: v = 8'd50;    7'd9: v = 8'd56;    7'd10: v = 8'd62;   7'd11: v = 8'd68;
            7'd12: v = 8'd74;   7'd13: v = 8'd80;   7'd14: v = 8'd86;   7'd15: v = 8'd92;
            7'd16: v = 8'd98;   7'd17: v = 8'd103;  7'd18: v = 8'd109;  7'd19: v = 8'd115;
            7'd20: v = 8'd120;  7'd21: v = 8'd126;  7'd22: v = 8'd131;  7'd23: v = 8'd136;
            7'd24: v = 8'd142;  7'd25: v = 8'd147;  7'd26: v = 8'd152;  7'd27: v = 8'd157;
            7'd28: v = 8'd162;  7'd29: v = 8'd167;  7'd30: v = 8'd171;  7'd31: v = 8'd176;
            7'd32: v = 8'd180;  7'd33: v = 8'd185;  7'd34: v = 8'd189;  7'd35: v = 8'd193;
            7'd36: v = 8'd197;  7'd37: v = 8'd201;  7'd38: v = 8'd205;  7'd39: v = 8'd208;
            7'd40: v = 8'd212;  7'd41: v = 8'd215;  7'd42: v = 8'd219;  7'd43: v = 8'd222;
            7'd44: v = 8'd225;  7'd45: v = 8'd228;  7'd46: v = 8'd231;  7'd47: v = 8'd233;
            7'd48: v = 8'd236;  7'd49: v = 8'd238;  7'd50: v = 8'd240;  7'd51: v = 8'd242;
            7'd52: v = 8'd244;  7'd53: v = 8'd246;  7'd54: v = 8'd247;  7'd55: v = 8'd249;
            7'd56: v = 8'd250;  7'd57: v = 8'd251;  7'd58: v = 8'd252;  7'd59: v = 8'd253;
            7'd60: v = 8'd254;  7'd61: v = 8'd254;  7'd62: v = 8'd255;  7'd63: v = 8'd255;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // x / 255, exact for x < 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // one random draw: eight Galois shifts
    function automatic logic [31:0] lfsr_draw(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        for (int n = 0; n < 8; n++) begin
            v = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
        end
        return v;
    endfunction

endpackage

FILE: rtl/lreg_fifo.sv
// Two-entry queue of frame descriptors between front and back.
module lreg_fifo
    import lreg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_data,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_frame_desc o_data
);

    t_frame_desc r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

FILE: rtl/lreg_front.sv
// Front end: frame counter, residues and phase accumulators, per-frame descriptor.
module lreg_front
    import lreg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mode       i_mode,
    input  logic        i_mode_wr,
    input  logic        i_valid,
    input  logic        i_blink,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_frame_desc o_desc
);

    logic [31:0]        r_frame;
    logic [15:0]        r_acc_br, r_acc_pu, r_acc_li, r_acc_ta;
    logic [2:0]         r_tens;
    logic [3:0]         r_ones;
    logic [SCAN_W-1:0]  r_scan_pos;
    logic [WIPE_W-1:0]  r_wipe_pos;
    logic [PIX_W-1:0]   r_mod_n;
    logic [1:0]         r_mod3;

    logic        accept, animated, wrap;
    logic [7:0]  phase;
    logic [6:0]  sidx;
    logic [7:0]  sval;
    logic [8:0]  ps;
    logic [15:0] li_prod;
    logic [10:0] ta_x;
    logic [23:0] ta_prod;
    logic [15:0] tri_v;
    logic [23:0] pu_prod;
    logic [7:0]  amp;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept;
    assign animated = (i_mode != MODE_OFF) && (i_mode != MODE_SOLID);
    assign wrap     = (r_frame == 32'hFFFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_mode_wr || (accept && animated && wrap)) begin
            r_frame    <= '0;
            r_acc_br   <= '0;
            r_acc_pu   <= '0;
            r_acc_li   <= '0;
            r_acc_ta   <= '0;
            r_tens     <= '0;
            r_ones     <= '0;
            r_scan_pos <= '0;
            r_wipe_pos <= '0;
            r_mod_n    <= '0;
            r_mod3     <= '0;
        end else if (accept && animated) begin
            r_frame  <= r_frame + 32'd1;
            r_acc_br <= r_acc_br + K_BREATH;
            r_acc_pu <= r_acc_pu + K_PULSE;
            r_acc_li <= r_acc_li + K_LISTEN;
            r_acc_ta <= r_acc_ta + K_TALK;
            if (r_ones == 4'd9) begin
                r_ones <= '0;
                r_tens <= (r_tens == 3'd5) ? 3'd0 : r_tens + 3'd1;
            end else begin
                r_ones <= r_ones + 4'd1;
            end
            r_scan_pos <= (r_scan_pos == SCAN_W'(SCAN_MOD - 1)) ? '0 : r_scan_pos + 1'b1;
            r_wipe_pos <= (r_wipe_pos == WIPE_W'(WIPE_MOD - 1)) ? '0 : r_wipe_pos + 1'b1;
            r_mod_n    <= (r_mod_n == PIX_W'(PIXEL_COUNT - 1)) ? '0 : r_mod_n + 1'b1;
            r_mod3     <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
        end
    end

    // one shared sine lookup, phase picked by mode
    always_comb begin
        case (i_mode)
            MODE_LISTENING: phase = r_acc_li[15:8];
            MODE_TALKING:   phase = r_acc_ta[15:8];
            default:        phase = r_acc_br[15:8];
        endcase
        sidx    = phase[6] ? (7'd64 - {1'b0, phase[5:0]}) : {1'b0, phase[5:0]};
        sval    = sine_quarter(sidx);
        ps      = phase[7] ? (9'd255 - {1'b0, sval}) : (9'd255 + {1'b0, sval});
        li_prod = 16'(ps) * 16'd89;
        ta_x    = 11'(ps) * 11'd3;
        ta_prod = 24'(ta_x) * 24'd6554;   // x * 3 / 10
        tri_v   = r_acc_pu[15] ? 16'(17'h10000 - {1'b0, r_acc_pu}) : r_acc_pu;
        pu_prod = 24'(tri_v) * 24'd255;
        case (i_mode)
            MODE_BREATHING: amp = ps[8:1];
            MODE_PULSE:     amp = pu_prod[22:15];
            MODE_LISTENING: amp = 8'd77 + div255(li_prod);
            MODE_TALKING:   amp = 8'd102 + ta_prod[23:16];
            default:        amp = '0;
        endcase
    end

    always_comb begin
        o_desc.mode       = i_mode;
        o_desc.blink      = i_blink;
        o_desc.amp        = amp;
        o_desc.hue_tens   = r_tens;
        o_desc.hue_ones   = r_ones;
        o_desc.scan_idx   = (r_scan_pos < SCAN_W'(PIXEL_COUNT)) ? PIX_W'(r_scan_pos)
                          : PIX_W'(SCAN_W'(SCAN_MOD) - r_scan_pos);
        o_desc.wipe_pos   = r_wipe_pos;
        o_desc.mod_n      = r_mod_n;
        o_desc.mod3       = r_mod3;
        o_desc.police_red = !r_frame[2];
    end

endmodule

FILE: rtl/lreg_back.sv
// Back end: walks the pixels of one frame and computes each color, two-stage pipe.
module lreg_back
    import lreg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fifo_valid,
    input  t_frame_desc i_desc,
    output logic        o_pop,
    input  logic [7:0]  i_base_r,
    input  logic [7:0]  i_base_g,
    input  logic [7:0]  i_base_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_pixel_index,
    output logic [15:0] o_color,
    output logic        o_last
);

    logic [PIX_W-1:0] r_pix;
    logic [1:0]       r_pmod3;
    logic [31:0]      r_lfsr;
    logic [2:0]       r_sector;
    logic [HUE_W-1:0] r_rem, r_upr;
    logic [7:0]       r_upq;

    logic             r1_valid, r1_scale, r1_last;
    logic [15:0]      r1_r, r1_g, r1_b;
    logic [3:0]       r1_idx;

    logic             r_o_valid, r_o_last;
    logic [15:0]      r_o_color;
    logic [3:0]       r_o_idx;

    logic ob_free, s1_move, s1_free, issue, last_pix;

    assign ob_free  = !r_o_valid || i_ready;
    assign s1_move  = r1_valid && ob_free;
    assign s1_free  = !r1_valid || s1_move;
    assign issue    = i_fifo_valid && s1_free;
    assign last_pix = (r_pix == PIX_W'(PIXEL_COUNT - 1));
    assign o_pop    = issue && last_pix;

    // rainbow hue in sector / remainder form, with a running quotient for the ramp
    logic [2:0]       c_sector, n_sector;
    logic [HUE_W-1:0] c_rem, c_upr, n_rem, n_upr;
    logic [7:0]       c_upq, n_upq;
    logic [HUE_W-1:0] t_rem, t_upr;
    logic [3:0]       t_sec;
    logic [7:0]       init_upq;
    logic             wrap_rem, wrap_upr;

    always_comb begin
        case (i_desc.hue_ones)
            4'd1: init_upq = 8'd25;
            4'd2: init_upq = 8'd51;
            4'd3: init_upq = 8'd76;
            4'd4: init_upq = 8'd102;
            4'd5: init_upq = 8'd127;
            4'd6: init_upq = 8'd153;
            4'd7: init_upq = 8'd178;
            4'd8: init_upq = 8'd204;
            4'd9: init_upq = 8'd229;
            default: init_upq = 8'd0;
        endcase
        if (r_pix == '0) begin
            c_sector = i_desc.hue_tens;
            c_rem    = HUE_W'(6 * PIXEL_COUNT) * HUE_W'(i_desc.hue_ones);
            c_upq    = init_upq;
            c_upr    = i_desc.hue_ones[0] ? HUE_W'(30 * PIXEL_COUNT) : '0;
        end else begin
            c_sector = r_sector;
            c_rem    = r_rem;
            c_upq    = r_upq;
            c_upr    = r_upr;
        end
        t_rem    = c_rem + HUE_W'(HUE_RSTEP);
        wrap_rem = (t_rem >= HUE_W'(HUE_D));
        n_rem    = wrap_rem ? t_rem - HUE_W'(HUE_D) : t_rem;
        t_upr    = c_upr + HUE_W'(UP_B);
        wrap_upr = (t_upr >= HUE_W'(HUE_D));
        n_upr    = wrap_upr ? t_upr - HUE_W'(HUE_D) : t_upr;
        n_upq    = c_upq + 8'(UP_A) + {7'd0, wrap_upr} - (wrap_rem ? 8'd255 : 8'd0);
        t_sec    = {1'b0, c_sector} + 4'(HUE_QSTEP) + {3'd0, wrap_rem};
        n_sector = (t_sec >= 4'd6) ? 3'(t_sec - 4'd6) : t_sec[2:0];
    end

    // per-pixel color selection
    logic [31:0]      draw;
    logic [7:0]       up, down, flick2;
    logic [7:0]       cr, cg, cb;
    logic [15:0]      pr, pg, pb;
    logic             scale;
    logic [PIX_W-1:0] sdist;
    logic [PIX_W:0]   cdist;
    logic [15:0]      d3r, d3g, d3b;
    logic [PIX_W+3:0] idx_ext;

    assign draw   = lfsr_draw(r_lfsr);
    assign up     = c_upq;
    assign down   = 8'd255 - c_upq - {7'd0, (c_upr != '0)};
    assign flick2 = {2'b0, draw[6:1]};
    assign sdist  = (r_pix > i_desc.scan_idx) ? r_pix - i_desc.scan_idx
                  : i_desc.scan_idx - r_pix;
    assign cdist  = (r_pix >= i_desc.mod_n) ? {1'b0, r_pix - i_desc.mod_n}
                  : {1'b0, r_pix} + (PIX_W+1)'(PIXEL_COUNT) - {1'b0, i_desc.mod_n};
    assign d3r    = 16'(i_base_r) * 16'd171;
    assign d3g    = 16'(i_base_g) * 16'd171;
    assign d3b    = 16'(i_base_b) * 16'd171;
    assign idx_ext = {4'd0, r_pix};

    always_comb begin
        cr = '0; cg = '0; cb = '0;
        scale = 1'b0;
        pr = '0; pg = '0; pb = '0;
        unique case (i_desc.mode)
            MODE_SOLID: begin
                cr = i_base_r; cg = i_base_g; cb = i_base_b;
            end
            MODE_RAINBOW: begin
                case (c_sector)
                    3'd0: begin cr = 8'd255; cg = up; end
                    3'd1: begin cr = down; cg = 8'd255; end
                    3'd2: begin cg = 8'd255; cb = up; end
                    3'd3: begin cg = down; cb = 8'd255; end
                    3'd4: begin cr = up; cb = 8'd255; end
                    default: begin cr = 8'd255; cb = down; end
                endcase
            end
            MODE_BREATHING, MODE_PULSE: begin
                scale = 1'b1;
                pr = 16'(i_base_r) * 16'(i_desc.amp);
                pg = 16'(i_base_g) * 16'(i_desc.amp);
                pb = 16'(i_base_b) * 16'(i_desc.amp);
            end
            MODE_SCANNER: begin
                if (sdist == '0) begin
                    cr = i_base_r; cg = i_base_g; cb = i_base_b;
                end else if (sdist == PIX_W'(1)) begin
                    cr = i_base_r >> 2; cg = i_base_g >> 2; cb = i_base_b >> 2;
                end
            end
            MODE_WIPE: begin
                if (WIPE_W'(r_pix) <= i_desc.wipe_pos &&
                    i_desc.wipe_pos < WIPE_W'(PIXEL_COUNT)) begin
                    cr = i_base_r; cg = i_base_g; cb = i_base_b;
                end
            end
            MODE_SPARKLE: begin
                if (draw[4:0] == 5'd0) begin
                    cr = i_base_r; cg = i_base_g; cb = i_base_b;
                end else begin
                    cr = i_base_r >> 4; cg = i_base_g >> 4; cb = i_base_b >> 4;
                end
            end
            MODE_POLICE: begin
                if (i_desc.police_red == (r_pix < PIX_W'(PIXEL_COUNT / 2))) cr = 8'd255;
                else cb = 8'd255;
            end
            MODE_FIRE: begin
                // 200 + 63 can pass full scale
                cr = (flick2 > 8'd55) ? 8'd255 : 8'd200 + flick2;
                cg = 8'd40 + flick2;
            end
            MODE_CHASE: begin
                if (cdist == '0) begin
                    cr = i_base_r; cg = i_base_g; cb = i_base_b;
                end else if (cdist == (PIX_W+1)'(1)) begin
                    cr = {1'b0, d3r[15:9]}; cg = {1'b0, d3g[15:9]}; cb = {1'b0, d3b[15:9]};
                end else if (cdist == (PIX_W+1)'(2)) begin
                    cr = i_base_r >> 3; cg = i_base_g >> 3; cb = i_base_b >> 3;
                end
            end
            MODE_THEATER: begin
                if (r_pmod3 == i_desc.mod3) begin
                    cr = i_base_r; cg = i_base_g; cb = i_base_b;
                end
            end
            MODE_LISTENING: begin
                scale = 1'b1;
                pg = 16'd80 * 16'(i_desc.amp);
                pb = 16'd200 * 16'(i_desc.amp);
            end
            MODE_THINKING: begin
                if (r_pix == i_desc.mod_n) begin
                    cr = 8'd180; cg = 8'd80; cb = 8'd220;
                end else begin
                    cr = 8'd20; cg = 8'd6; cb = 8'd30;
                end
            end
            MODE_TALKING: begin
                scale = 1'b1;
                pg = 16'd220 * 16'(i_desc.amp);
                pb = 16'd60 * 16'(i_desc.amp);
            end
            MODE_RECORDING: begin
                if (i_desc.blink) cr = 8'd255;
            end
            default: ;
        endcase
        if (!scale) begin
            pr = {8'd0, cr}; pg = {8'd0, cg}; pb = {8'd0, cb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix   <= '0;
            r_pmod3 <= '0;
            r_lfsr  <= LFSR_SEED;
        end else if (issue) begin
            r_pix   <= last_pix ? '0 : r_pix + 1'b1;
            r_pmod3 <= (last_pix || r_pmod3 == 2'd2) ? 2'd0 : r_pmod3 + 2'd1;
            if (i_desc.mode == MODE_SPARKLE || i_desc.mode == MODE_FIRE) begin
                r_lfsr <= draw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_sector <= n_sector;
            r_rem    <= n_rem;
            r_upq    <= n_upq;
            r_upr    <= n_upr;
            r1_scale <= scale;
            r1_r     <= pr;
            r1_g     <= pg;
            r1_b     <= pb;
            r1_idx   <= idx_ext[3:0];
            r1_last  <= last_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (issue)        r1_valid <= 1'b1;
            else if (s1_move) r1_valid <= 1'b0;
            if (s1_move)      r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
        end
    end

    logic [7:0] fr, fg, fb;
    assign fr = r1_scale ? div255(r1_r) : r1_r[7:0];
    assign fg = r1_scale ? div255(r1_g) : r1_g[7:0];
    assign fb = r1_scale ? div255(r1_b) : r1_b[7:0];

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_color <= {fr[7:3], fg[7:2], fb[7:3]};
            r_o_idx   <= r1_idx;
            r_o_last  <= r1_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_index = r_o_idx;
    assign o_color       = r_o_color;
    assign o_last        = r_o_last;

endmodule

FILE: rtl/led_ring_effect_generator_core.sv
// Top level of the LED ring effect generator: config registers, front, queue, back.
//
// channel   | dir | fields (low bit up)
// s_axis    | in  | tdata[0] blink_phase, [7:1] zero; one word per frame tick
// m_axis    | out | tdata[3:0] pixel_index, [19:4] color_565, [23:20] zero; tlast last_pixel
// cfg       | in  | we, addr (0 mode, 1 red, 2 green, 3 blue), data[7:0]
//
// Each tick word yields PIXEL_COUNT (12) output words, one per cycle while the sink is
// ready; the back end's pixel walker sets the rate.
// The front takes a tick whenever the two-entry descriptor queue has room.
// A taken tick's first pixel passes the descriptor queue, color stage and output reg.
// Reset is synchronous, active low; no clearing pass. Output stalls back up
// through the pipe into the queue and then to s_axis tready.
module led_ring_effect_generator_core
    import lreg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] blink_phase
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [3:0] pixel_index, [19:4] color_565
    output logic        o_m_axis_tlast,   // last_pixel
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    t_mode       r_mode;
    logic [7:0]  r_base_r, r_base_g, r_base_b;
    logic        mode_wr;
    logic        fifo_full, fifo_valid, push, pop;
    t_frame_desc desc_in, desc_out;
    logic [3:0]  pix_idx;
    logic [15:0] color;

    assign mode_wr = i_cfg_we && (i_cfg_addr == CFG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SOLID;
            r_base_r <= '0;
            r_base_g <= '0;
            r_base_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE:  r_mode   <= t_mode'(i_cfg_data[3:0]);
                CFG_RED:   r_base_r <= i_cfg_data;
                CFG_GREEN: r_base_g <= i_cfg_data;
                CFG_BLUE:  r_base_b <= i_cfg_data;
                default: ;   // unknown index ignored
            endcase
        end
    end

    lreg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_mode_wr (mode_wr),
        .i_valid (i_s_axis_tvalid),
        .i_blink (i_s_axis_tdata[0]),
        .i_full  (fifo_full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_desc  (desc_in)
    );

    lreg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc_in),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_data  (desc_out)
    );

    lreg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_valid  (fifo_valid),
        .i_desc        (desc_out),
        .o_pop         (pop),
        .i_base_r      (r_base_r),
        .i_base_g      (r_base_g),
        .i_base_b      (r_base_b),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_pixel_index (pix_idx),
        .o_color       (color),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'd0, color, pix_idx};

    localparam logic [PIX_W+3:0] LAST_EXT = (PIX_W+4)'(PIXEL_COUNT - 1);

    // the frame-closing word carries the last ring position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (pix_idx == LAST_EXT[3:0]))
        else $error("tlast on wrong pixel");

    // queue never takes a tick while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_full |-> !push)
        else $error("descriptor queue overflow");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a mode write lands in the mode register
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_wr |=> (r_mode == t_mode'($past(i_cfg_data[3:0]))))
        else $error("mode write lost");

endmodule

FILE: dv/led_ring_effect_checker.sv
// Pixel stream checker: predicts each frame's colors and compares them with the output.
`timescale 1ns / 1ps
module led_ring_effect_checker
    import lreg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] i_m_axis_tdata,
    input  logic        i_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_pixels_seen
);

    typedef struct packed {
        logic [3:0]  pix;
        logic [15:0] rgb565;
        logic        last;
    } t_pixel;

    t_pixel pixel_q[$];

    t_mode       cur_mode;
    logic [7:0]  red_c, green_c, blue_c;
    logic [31:0] frame_cnt;
    logic [31:0] rng;

    localparam int SINE_LUT [65] = '{
        0, 6, 13, 19, 25, 31, 37, 44, 50, 56, 62, 68, 74, 80, 86, 92,
        98, 103, 109, 115, 120, 126, 131, 136, 142, 147, 152, 157, 162, 167, 171, 176,
        180, 185, 189, 193, 197, 201, 205, 208, 212, 215, 219, 222, 225, 228, 231, 233,
        236, 238, 240, 242, 244, 246, 247, 249, 250, 251, 252, 253, 254, 254, 255, 255,
        255};

    // biased sine 0..510 for phase step k
    function automatic int sine_biased(logic [31:0] f, int k);
        logic [31:0] p;
        int idx, v;
        p = (f * k) & 32'hFFFF;
        idx = p[15:8];
        v = (idx[6]) ? SINE_LUT[64 - idx[5:0]] : SINE_LUT[idx[5:0]];
        if (idx[7]) v = -v;
        return v + 255;
    endfunction

    function automatic logic [15:0] to565(int r, int g, int b);
        logic [7:0] r8, g8, b8;
        r8 = r; g8 = g; b8 = b;
        return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    function automatic logic [31:0] next_random(logic [31:0] s);
        logic [31:0] v;
        v = s;
        for (int n = 0; n < 8; n++) v = v[0] ? ((v >> 1) ^ 32'h80200003) : (v >> 1);
        return v;
    endfunction

    // build the twelve expected pixels of one frame tick
    task automatic predict_frame(logic blink);
        int n, amp, r, g, b, pos, idx, d, hn, sector, rem, up, down, flick;
        logic [31:0] f, p, tri_v;
        n = PIXEL_COUNT;
        f = frame_cnt;
        amp = 0;
        case (cur_mode)
            MODE_BREATHING: amp = sine_biased(f, 522) >> 1;
            MODE_PULSE: begin
                p = (f * 4915) & 32'hFFFF;
                tri_v = (p < 32768) ? p : 65536 - p;
                amp = (tri_v * 255) >> 15;
            end
            MODE_LISTENING: amp = 77 + sine_biased(f, 834) * 89 / 255;
            MODE_TALKING: amp = 102 + sine_biased(f, 2608) * 153 / 510;
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            r = 0; g = 0; b = 0;
            case (cur_mode)
                MODE_SOLID: begin r = red_c; g = green_c; b = blue_c; end
                MODE_RAINBOW: begin
                    hn = (6 * (f % 60) * n + 360 * i) % (360 * n);
                    sector = hn / (60 * n);
                    rem = hn % (60 * n);
                    up = rem * 255 / (60 * n);
                    down = (60 * n - rem) * 255 / (60 * n);
                    case (sector)
                        0: begin r = 255; g = up; end
                        1: begin r = down; g = 255; end
                        2: begin g = 255; b = up; end
                        3: begin g = down; b = 255; end
                        4: begin r = up; b = 255; end
                        default: begin r = 255; b = down; end
                    endcase
                end
                MODE_BREATHING, MODE_PULSE: begin
                    r = red_c * amp / 255; g = green_c * amp / 255; b = blue_c * amp / 255;
                end
                MODE_SCANNER: begin
                    pos = f % (2 * n - 2);
                    idx = (pos < n) ? pos : 2 * n - 2 - pos;
                    d = (i > idx) ? i - idx : idx - i;
                    if (d == 0) begin r = red_c; g = green_c; b = blue_c; end
                    else if (d == 1) begin r = red_c / 4; g = green_c / 4; b = blue_c / 4; end
                end
                MODE_WIPE: begin
                    pos = f % (n + 4);
                    if (i <= pos && pos < n) begin r = red_c; g = green_c; b = blue_c; end
                end
                MODE_SPARKLE: begin
                    rng = next_random(rng);
                    if (rng[4:0] == 0) begin r = red_c; g = green_c; b = blue_c; end
                    else begin r = red_c / 16; g = green_c / 16; b = blue_c / 16; end
                end
                MODE_POLICE: begin
                    if ((((f / 4) & 1) == 0) == (i < n / 2)) r = 255; else b = 255;
                end
                MODE_FIRE: begin
                    rng = next_random(rng);
                    flick = rng[6:0];
                    r = 200 + flick / 2;
                    if (r > 255) r = 255;
                    g = 40 + flick / 2;
                end
                MODE_CHASE: begin
                    d = (i + n - f % n) % n;
                    if (d == 0) begin r = red_c; g = green_c; b = blue_c; end
                    else if (d == 1) begin r = red_c / 3; g = green_c / 3; b = blue_c / 3; end
                    else if (d == 2) begin r = red_c / 8; g = green_c / 8; b = blue_c / 8; end
                end
                MODE_THEATER: if (i % 3 == f % 3) begin r = red_c; g = green_c; b = blue_c; end
                MODE_LISTENING: begin g = 80 * amp / 255; b = 200 * amp / 255; end
                MODE_THINKING: begin
                    if (i == f % n) begin r = 180; g = 80; b = 220; end
                    else begin r = 20; g = 6; b = 30; end
                end
                MODE_TALKING: begin g = 220 * amp / 255; b = 60 * amp / 255; end
                MODE_RECORDING: if (blink) r = 255;
                default: ;
            endcase
            pixel_q.push_back('{pix: i[3:0], rgb565: to565(r, g, b), last: (i == n - 1)});
        end
        if (cur_mode != MODE_OFF && cur_mode != MODE_SOLID) frame_cnt = f + 1;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            cur_mode  = MODE_SOLID;
            red_c     = '0;
            green_c   = '0;
            blue_c    = '0;
            frame_cnt = '0;
            rng       = LFSR_SEED;
            pixel_q.delete();
            o_fail_count  <= 0;
            o_pixels_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE: begin
                        cur_mode = t_mode'(i_cfg_data[3:0]);
                        frame_cnt = '0;
                    end
                    CFG_RED:   red_c = i_cfg_data;
                    CFG_GREEN: green_c = i_cfg_data;
                    CFG_BLUE:  blue_c = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) predict_frame(i_s_axis_tdata[0]);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_pixels_seen <= o_pixels_seen + 1;
                if (pixel_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: pixel word %h with nothing expected", i_m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (i_m_axis_tdata[3:0] !== want.pix
                            || i_m_axis_tdata[19:4] !== want.rgb565
                            || i_m_axis_tdata[23:20] !== 4'd0
                            || i_m_axis_tlast !== want.last) begin
                        if (o_fail_count < 10)
                            $display({"ERROR: mode %0d pixel exp idx %0d rgb %h last %b, ",
                                      "got idx %0d rgb %h last %b"},
                                cur_mode, want.pix, want.rgb565, want.last, i_m_axis_tdata[3:0],
                                i_m_axis_tdata[19:4], i_m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = pixel_q.size();

endmodule

FILE: dv/tb_led_ring_effect_generator_core.sv
// Testbench top: clock, reset, tick stimulus, register programming and verdict.
`timescale 1ns / 1ps
module tb_led_ring_effect_generator_core;
    import lreg_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [7:0]  cfg_data = '0;

    int fail_count, pending, pixels_seen;
    int ticks_sent = 0;
    int cycle = 0;
    int send_idle_pct = 0;   // chance per cycle that the tick sender rests
    int recv_idle_pct = 0;   // chance per cycle that the pixel sink stalls
    bit hold_sink = 1'b0;    // long back-pressure window

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    led_ring_effect_generator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    led_ring_effect_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_pixels_seen(pixels_seen)
    );

    // pixel sink: random stalls, or a solid hold while hold_sink is set
    always @(posedge i_clk) begin
        m_tready <= !hold_sink && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("led_ring_effect_generator_core verification failed");
            $finish;
        end
    end

    // one register write; block must be idle
    task automatic cfg_poke(logic [2:0] addr, logic [7:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // wait until every predicted pixel has come out, plus pipeline slack
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // offer one tick word; holds tvalid across back-to-back words
    // tready is looked at mid-cycle, so it is the value the next edge sees
    task automatic send_tick(logic [7:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic stop_ticks();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // reprogram the full register set between bursts
    task automatic set_effect(logic [3:0] mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        drain();
        cfg_poke(CFG_RED, r);
        cfg_poke(CFG_GREEN, g);
        cfg_poke(CFG_BLUE, b);
        cfg_poke(CFG_MODE, {4'd0, mode});
    endtask

    initial begin
        int burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state is solid black
        send_tick(8'h00);
        stop_ticks();
        // every mode once, red zero or full, green full, blue A5 or full, both blink values
        for (int m = 0; m < 16; m++) begin
            set_effect(m[3:0], (m % 2) ? 8'hFF : 8'h00, 8'hFF, (m % 3) ? 8'hA5 : 8'hFF);
            send_tick(8'h01);
            send_tick(8'hFE);
            stop_ticks();
        end
        // color write keeps the frame counter; unknown register index ignored
        drain();
        cfg_poke(CFG_RED, 8'h80);
        cfg_poke(3'd5, 8'h00);
        cfg_poke(3'd7, 8'hFF);
        send_tick(8'h01);
        stop_ticks();

        // random phases: sender 13 / sink 82, then swapped, then free-running
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 82 : 0;
            recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 13 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                set_effect(4'($urandom_range(15)), 8'($urandom), 8'($urandom),
                           $urandom_range(1) ? 8'hFF : 8'($urandom));
                burst = $urandom_range(7, 16);
                for (int t = 0; t < burst; t++) send_tick(8'($urandom));
                stop_ticks();
            end
        end

        // back-pressure: sink held off while ticks keep coming
        set_effect(MODE_SPARKLE, 8'hFF, 8'h40, 8'h10);
        fork
            begin
                hold_sink = 1'b1;
                repeat (150) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                for (int t = 0; t < 10; t++) send_tick(8'($urandom));
                stop_ticks();
            end
        join

        drain();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d frame ticks over all 16 effects, %0d pixel words checked.",
                 ticks_sent, pixels_seen);
        if (fail_count == 0 && pending == 0)
            $display("led_ring_effect_generator_core verification clean");
        else
            $display("led_ring_effect_generator_core verification failed");
        $finish;
    end

endmodule
